// File: design/mbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsd_pkg
// Shared register map, reset constants and result type of the multiplexed button scanner.
// ----------------------------------------------------------------------------
package mbsd_pkg;

	typedef enum logic [1:0] {
		REG_CHANNEL_COUNT = 2'd0,
		REG_SETTLE_US     = 2'd1,
		REG_DEBOUNCE_MS   = 2'd2
	} reg_idx_t;

	localparam logic [4:0]  CHANNEL_COUNT_RESET = 5'd16;
	localparam logic [15:0] SETTLE_US_RESET     = 16'd10;
	localparam logic [15:0] DEBOUNCE_MS_RESET   = 16'd20;

	typedef struct packed {
		logic [3:0]  select_addr;
		logic [15:0] pressed;
		logic        sampled;
	} result_t;

endpackage

// File: design/mux_button_scan_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mux_button_scan_debounce
// Round-robin scan of a multiplexed button matrix with per-channel debounce.
// ----------------------------------------------------------------------------
// The block takes one microsecond tick per clock cycle while in_ready is high
// and returns exactly one result per tick; all scan, settle and debounce state
// is updated in the cycle the tick is accepted, by a single pass of logic whose
// longest path is the 32-bit elapsed-time subtract and compare. A two-entry
// output buffer lets ticks keep arriving while a result waits, so in_ready
// drops only when both entries are full. The per-channel change times live in
// flip-flops cleared by reset, so no clearing pass is needed.
module mux_button_scan_debounce #(
	parameter int CHANNELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        sig_level,
	input  logic        ms_tick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  select_addr,
	output logic [15:0] pressed,
	output logic        sampled
);
	import mbsd_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [4:0]  channel_count_q;
	logic [15:0] settle_us_q;
	logic [15:0] debounce_ms_q;

	logic [CW-1:0]       cur_q;
	logic [15:0]         settle_left_q;
	logic [CHANNELS-1:0] raw_q;
	logic [CHANNELS-1:0] stable_q;
	logic [31:0]         last_change_q [CHANNELS];
	logic [31:0]         ms_time_q;
	logic                priming_q;

	result_t out_q, skid_q, res;
	logic    out_valid_q, skid_valid_q;

	logic                accept, take, cfg_wr;
	reg_idx_t            reg_idx;
	logic [4:0]          n_active, cur_inc;
	logic [15:0]         settle_dec, mask16, stable16;
	logic                do_sample, wrap, prev_bit, stab_bit, new_stab;
	logic [31:0]         ms_next, last_cur, new_last, elapsed;
	logic [CW-1:0]       next_ch, cur_next;
	logic [CHANNELS-1:0] stable_next;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CHANNEL_COUNT_RESET;
			settle_us_q     <= SETTLE_US_RESET;
			debounce_ms_q   <= DEBOUNCE_MS_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[4:0];
				REG_SETTLE_US:     settle_us_q     <= pwdata[15:0];
				REG_DEBOUNCE_MS:   debounce_ms_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CHANNEL_COUNT: prdata = {27'd0, channel_count_q};
			REG_SETTLE_US:     prdata = {16'd0, settle_us_q};
			REG_DEBOUNCE_MS:   prdata = {16'd0, debounce_ms_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign in_ready = ~skid_valid_q;
	assign accept   = in_valid & in_ready;
	assign take     = out_valid_q & out_ready;

	always_comb begin
		if (channel_count_q == 5'd0) begin
			n_active = 5'd1;
		end else if (channel_count_q > 5'(CHANNELS)) begin
			n_active = 5'(CHANNELS);
		end else begin
			n_active = channel_count_q;
		end
		for (int i = 0; i < 16; i++) begin
			mask16[i] = (5'(i) < n_active);
		end

		ms_next    = ms_time_q + {31'd0, ms_tick};
		settle_dec = (settle_left_q != 16'd0) ? settle_left_q - 16'd1 : 16'd0;
		do_sample  = (settle_dec == 16'd0);

		prev_bit = raw_q[cur_q];
		stab_bit = stable_q[cur_q];
		last_cur = last_change_q[cur_q];
		if (priming_q || (sig_level != prev_bit)) begin
			new_last = ms_next;
		end else begin
			new_last = last_cur;
		end
		elapsed = ms_next - new_last;
		if (priming_q) begin
			new_stab = sig_level;
		end else if ((sig_level != stab_bit) && (elapsed >= {16'd0, debounce_ms_q})) begin
			new_stab = sig_level;
		end else begin
			new_stab = stab_bit;
		end

		cur_inc = 5'(cur_q) + 5'd1;
		wrap    = (cur_inc >= n_active);
		next_ch = wrap ? '0 : cur_inc[CW-1:0];

		stable_next = stable_q;
		cur_next    = cur_q;
		if (do_sample) begin
			stable_next[cur_q] = new_stab;
			cur_next           = next_ch;
		end
		stable16 = 16'(stable_next);

		res.select_addr = 4'(cur_next);
		res.pressed     = ~stable16 & mask16;
		res.sampled     = do_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q         <= '0;
			settle_left_q <= SETTLE_US_RESET;
			raw_q         <= '1;
			stable_q      <= '1;
			ms_time_q     <= 32'd0;
			priming_q     <= 1'b1;
			for (int i = 0; i < CHANNELS; i++) begin
				last_change_q[i] <= 32'd0;
			end
		end else if (accept) begin
			ms_time_q <= ms_next;
			stable_q  <= stable_next;
			cur_q     <= cur_next;
			if (do_sample) begin
				settle_left_q        <= settle_us_q;
				raw_q[cur_q]         <= sig_level;
				last_change_q[cur_q] <= new_last;
				if (wrap) begin
					priming_q <= 1'b0;
				end
			end else begin
				settle_left_q <= settle_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b0;
			out_valid_q  <= skid_valid_q | accept;
		end else if (accept) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign select_addr = out_q.select_addr;
	assign pressed     = out_q.pressed;
	assign sampled     = out_q.sampled;

`ifndef ASSERT_OFF
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid entry holds a result while the output entry is empty.");

	a_channel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, 4'(cur_q)} < 5'(CHANNELS))
		else $error("Current channel lies beyond the configured channel limit.");

	a_priming_ends_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(priming_q) |-> ($past(accept) && $past(do_sample) && (cur_q == '0)))
		else $error("First pass ended without a sampled wrap to channel zero.");

	a_settle_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && do_sample) |=> (settle_left_q == $past(settle_us_q)))
		else $error("Settle counter was not reloaded after a sample.");
`endif

endmodule

// File: test/tb_mux_button_scan_debounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mux_button_scan_debounce
// Self-checking bench for the multiplexed button scanner with debounce.
// ----------------------------------------------------------------------------
// A clocked driver sends microsecond ticks from a queue that the stimulus
// process fills. A clocked monitor checks every result transaction against a
// scan model kept inside the bench. A short directed sequence covers priming,
// the clamping of the channel count, a count that shrinks below the current
// channel, and debounce at zero and above. Random phases then follow with
// fresh register settings, held and bouncing line levels, and sender and
// receiver idling. Register writes happen only while the scanner is idle.
module tb_mux_button_scan_debounce;
	import mbsd_pkg::*;

	localparam int CHANNELS = 16;

	typedef struct packed {
		logic level;
		logic ms;
	} tick_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        sig_level = 1'b1;
	logic        ms_tick = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  select_addr;
	logic [15:0] pressed;
	logic        sampled;

	logic [4:0]  cfg_count;
	logic [15:0] cfg_settle;
	logic [15:0] cfg_debounce;
	logic [3:0]  scan_ch;
	logic [15:0] settle_cnt;
	logic [15:0] raw_bits;
	logic [15:0] stable_bits;
	logic [31:0] change_ms [16];
	logic [31:0] ms_now;
	logic        first_pass;

	tick_t   tick_queue[$];
	result_t expected_scans[$];
	result_t scan_want;
	int      send_idle_pct = 0;
	int      stall_pct = 0;
	int      mismatches = 0;
	int      scans_checked = 0;
	int      samples_seen = 0;
	int      settings_used = 0;

	mux_button_scan_debounce #(
		.CHANNELS(CHANNELS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sig_level(sig_level),
		.ms_tick(ms_tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.select_addr(select_addr),
		.pressed(pressed),
		.sampled(sampled)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic result_t next_scan_result(input logic lvl, input logic msb);
		int          n;
		logic [4:0]  nxt;
		logic        stab;
		logic [15:0] mask;
		result_t     r;
		n = (cfg_count == 0) ? 1 : ((cfg_count > CHANNELS) ? CHANNELS : int'(cfg_count));
		if (msb)
			ms_now = ms_now + 32'd1;
		if (settle_cnt != 0)
			settle_cnt = settle_cnt - 16'd1;
		r.sampled = 1'b0;
		if (settle_cnt == 0) begin
			stab = stable_bits[scan_ch];
			if (first_pass) begin
				change_ms[scan_ch] = ms_now;
				stab = lvl;
			end else begin
				if (lvl != raw_bits[scan_ch])
					change_ms[scan_ch] = ms_now;
				if (lvl != stab && (ms_now - change_ms[scan_ch]) >= {16'd0, cfg_debounce})
					stab = lvl;
			end
			stable_bits[scan_ch] = stab;
			raw_bits[scan_ch] = lvl;
			nxt = {1'b0, scan_ch} + 5'd1;
			if (nxt >= n) begin
				nxt = '0;
				first_pass = 1'b0;
			end
			scan_ch = nxt[3:0];
			settle_cnt = cfg_settle;
			r.sampled = 1'b1;
		end
		mask = (n >= 16) ? 16'hFFFF : 16'((32'd1 << n) - 32'd1);
		r.select_addr = scan_ch;
		r.pressed = ~stable_bits & mask;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_scans.push_back(next_scan_result(sig_level, ms_tick));
				tick_queue.delete(0);
			end
			if (!in_valid || in_ready) begin
				if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					sig_level <= tick_queue[0].level;
					ms_tick <= tick_queue[0].ms;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && out_valid && out_ready) begin
			scans_checked++;
			if (sampled)
				samples_seen++;
			if (expected_scans.size() == 0) begin
				$display("%0t: unexpected transaction: select_addr=%0d pressed=%h sampled=%0b",
					$time, select_addr, pressed, sampled);
				mismatches++;
			end else begin
				scan_want = expected_scans.pop_front();
				if (select_addr !== scan_want.select_addr) begin
					$display("%0t: select_addr expected %0d, got %0d",
						$time, scan_want.select_addr, select_addr);
					mismatches++;
				end
				if (pressed !== scan_want.pressed) begin
					$display("%0t: pressed expected %h, got %h", $time, scan_want.pressed, pressed);
					mismatches++;
				end
				if (sampled !== scan_want.sampled) begin
					$display("%0t: sampled expected %0b, got %0b", $time, scan_want.sampled, sampled);
					mismatches++;
				end
			end
		end
	end

	task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CHANNEL_COUNT: cfg_count = value[4:0];
			REG_SETTLE_US: cfg_settle = value[15:0];
			REG_DEBOUNCE_MS: cfg_debounce = value[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		do @(negedge clk);
		while (tick_queue.size() != 0 || in_valid || expected_scans.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic add_tick(input logic lvl, input logic msb);
		tick_queue.push_back(tick_t'{lvl, msb});
	endtask

	task automatic random_phase(input int n_items, input int ms_pct);
		int   left;
		int   run;
		logic lvl;
		left = n_items;
		lvl = 1'b1;
		@(negedge clk);
		while (left > 0) begin
			if ($urandom_range(99) < 15) begin
				add_tick(1'($urandom_range(1)), $urandom_range(99) < ms_pct);
				left--;
			end else begin
				if ($urandom_range(3) != 0)
					lvl = ~lvl;
				run = $urandom_range(60, 1);
				repeat (run) add_tick(lvl, $urandom_range(99) < ms_pct);
				left -= run;
			end
		end
	endtask

	initial begin
		int phase_no;
		int ms_pct;
		cfg_count = CHANNEL_COUNT_RESET;
		cfg_settle = SETTLE_US_RESET;
		cfg_debounce = DEBOUNCE_MS_RESET;
		scan_ch = '0;
		settle_cnt = SETTLE_US_RESET;
		raw_bits = '1;
		stable_bits = '1;
		for (int i = 0; i < 16; i++)
			change_ms[i] = '0;
		ms_now = '0;
		first_pass = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// The reset settle time runs out before the first sample of channel 0.
		cfg_write(REG_CHANNEL_COUNT, 32'd3);
		cfg_write(REG_SETTLE_US, 32'd0);
		cfg_write(REG_DEBOUNCE_MS, 32'd0);
		settings_used++;
		@(negedge clk);
		for (int i = 0; i < 10; i++)
			add_tick(i[0], 1'b1);
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b1);
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b1);
		add_tick(1'b0, 1'b0);
		drain();

		// A zero count scans channel 0 alone; a bounce must hold two ms.
		cfg_write(REG_CHANNEL_COUNT, 32'd0);
		cfg_write(REG_DEBOUNCE_MS, 32'd2);
		settings_used++;
		@(negedge clk);
		add_tick(1'b1, 1'b0);
		add_tick(1'b1, 1'b1);
		add_tick(1'b1, 1'b1);
		add_tick(1'b0, 1'b1);
		add_tick(1'b1, 1'b1);
		drain();

		// A count above the channel limit, then one below the current channel.
		cfg_write(REG_CHANNEL_COUNT, 32'd17);
		settings_used++;
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			add_tick(1'b0, i[0]);
		drain();
		cfg_write(REG_CHANNEL_COUNT, 32'd3);
		settings_used++;
		@(negedge clk);
		add_tick(1'b0, 1'b1);
		add_tick(1'b1, 1'b0);
		drain();

		for (phase_no = 0; phase_no < 10; phase_no++) begin
			case (phase_no % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 80; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 80; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			case ($urandom_range(9))
				0: cfg_write(REG_CHANNEL_COUNT, 32'd0);
				1: cfg_write(REG_CHANNEL_COUNT, 32'd16);
				2: cfg_write(REG_CHANNEL_COUNT, $urandom_range(31, 17));
				3: cfg_write(REG_CHANNEL_COUNT, 32'd1);
				default: cfg_write(REG_CHANNEL_COUNT, $urandom_range(6, 2));
			endcase
			case ($urandom_range(5))
				0: cfg_write(REG_SETTLE_US, 32'd0);
				1: cfg_write(REG_SETTLE_US, $urandom_range(40, 8));
				default: cfg_write(REG_SETTLE_US, $urandom_range(3, 0));
			endcase
			case ($urandom_range(6))
				0: cfg_write(REG_DEBOUNCE_MS, 32'd0);
				1: cfg_write(REG_DEBOUNCE_MS, 32'hFFFF);
				2: cfg_write(REG_DEBOUNCE_MS, $urandom_range(65534, 100));
				default: cfg_write(REG_DEBOUNCE_MS, $urandom_range(6, 1));
			endcase
			settings_used++;
			case ($urandom_range(3))
				0: ms_pct = 0;
				1: ms_pct = 20;
				2: ms_pct = 60;
				default: ms_pct = 100;
			endcase
			random_phase($urandom_range(140, 100), ms_pct);
			drain();
		end

		// The longest settle time takes effect at the next reload.
		send_idle_pct = 35;
		stall_pct = 35;
		cfg_write(REG_SETTLE_US, 32'hFFFF);
		cfg_write(REG_CHANNEL_COUNT, 32'd16);
		settings_used++;
		random_phase(24, 100);
		drain();

		$display("Checked %0d scan results over %0d register settings.",
			scans_checked, settings_used);
		$display("Of those results, %0d sampled a channel.", samples_seen);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
